// File: sv/aff_pkg.sv
`default_nettype none
package aff_pkg;

  localparam int unsigned ALPHA_LEN   = 69;
  localparam int unsigned IDX_W       = 7;
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned PROD_W      = 13;
  localparam int unsigned RECIP       = 949;
  localparam int unsigned RECIP_W     = 10;
  localparam int unsigned RECIP_SHIFT = 16;
  localparam int unsigned PADDR_W     = 4;
  localparam int unsigned PDATA_W     = 32;

  localparam logic [1:0] REG_KEY_MULT     = 2'd0;
  localparam logic [1:0] REG_KEY_ADD      = 2'd1;
  localparam logic [1:0] REG_DECRYPT_MODE = 2'd2;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CHAR_W-1:0] char_t;

  typedef struct packed {
    logic found;
    idx_t idx;
  } sym_t;

  function automatic idx_t aff_reduce(input idx_t v);
    idx_t r;
    r = v;
    if (v >= IDX_W'(ALPHA_LEN)) begin
      r = v - IDX_W'(ALPHA_LEN);
    end
    return r;
  endfunction

  function automatic idx_t aff_sub_mod(input idx_t p, input idx_t b);
    logic [IDX_W:0] t;
    t = {1'b0, p} + (IDX_W+1)'(ALPHA_LEN) - {1'b0, b};
    if (t >= (IDX_W+1)'(ALPHA_LEN)) begin
      t = t - (IDX_W+1)'(ALPHA_LEN);
    end
    return t[IDX_W-1:0];
  endfunction

  function automatic idx_t aff_inv(input idx_t a);
    idx_t r;
    case (a)
      7'd1:  r = 7'd1;
      7'd2:  r = 7'd35;
      7'd4:  r = 7'd52;
      7'd5:  r = 7'd14;
      7'd7:  r = 7'd10;
      7'd8:  r = 7'd26;
      7'd10: r = 7'd7;
      7'd11: r = 7'd44;
      7'd13: r = 7'd16;
      7'd14: r = 7'd5;
      7'd16: r = 7'd13;
      7'd17: r = 7'd65;
      7'd19: r = 7'd40;
      7'd20: r = 7'd38;
      7'd22: r = 7'd22;
      7'd25: r = 7'd58;
      7'd26: r = 7'd8;
      7'd28: r = 7'd37;
      7'd29: r = 7'd50;
      7'd31: r = 7'd49;
      7'd32: r = 7'd41;
      7'd34: r = 7'd67;
      7'd35: r = 7'd2;
      7'd37: r = 7'd28;
      7'd38: r = 7'd20;
      7'd40: r = 7'd19;
      7'd41: r = 7'd32;
      7'd43: r = 7'd61;
      7'd44: r = 7'd11;
      7'd47: r = 7'd47;
      7'd49: r = 7'd31;
      7'd50: r = 7'd29;
      7'd52: r = 7'd4;
      7'd53: r = 7'd56;
      7'd55: r = 7'd64;
      7'd56: r = 7'd53;
      7'd58: r = 7'd25;
      7'd59: r = 7'd62;
      7'd61: r = 7'd43;
      7'd62: r = 7'd59;
      7'd64: r = 7'd55;
      7'd65: r = 7'd17;
      7'd67: r = 7'd34;
      7'd68: r = 7'd68;
      default: r = 7'd0;
    endcase
    return r;
  endfunction

  function automatic sym_t aff_lookup(input char_t c);
    sym_t s;
    s.found = 1'b1;
    s.idx   = '0;
    if (c >= 8'h61 && c <= 8'h7a) begin
      s.idx = IDX_W'(c - 8'h61);
    end else if (c >= 8'h41 && c <= 8'h5a) begin
      s.idx = IDX_W'(c - 8'h41 + 8'd30);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      s.idx = IDX_W'(c - 8'h30 + 8'd57);
    end else if (c == 8'h2c) begin
      s.idx = 7'd26;
    end else if (c == 8'h2e) begin
      s.idx = 7'd27;
    end else if (c == 8'h2d) begin
      s.idx = 7'd28;
    end else if (c == 8'h5f) begin
      s.idx = 7'd29;
    end else if (c == 8'h20) begin
      s.idx = 7'd56;
    end else if (c == 8'h28) begin
      s.idx = 7'd67;
    end else if (c == 8'h29) begin
      s.idx = 7'd68;
    end else begin
      s.found = 1'b0;
    end
    return s;
  endfunction

  function automatic char_t aff_symbol(input idx_t i);
    char_t c;
    if (i < 7'd26) begin
      c = CHAR_W'(i) + 8'h61;
    end else if (i >= 7'd30 && i < 7'd56) begin
      c = CHAR_W'(i) - 8'd30 + 8'h41;
    end else if (i >= 7'd57 && i < 7'd67) begin
      c = CHAR_W'(i) - 8'd57 + 8'h30;
    end else begin
      case (i)
        7'd26:   c = 8'h2c;
        7'd27:   c = 8'h2e;
        7'd28:   c = 8'h2d;
        7'd29:   c = 8'h5f;
        7'd56:   c = 8'h20;
        7'd67:   c = 8'h28;
        7'd68:   c = 8'h29;
        default: c = 8'h00;
      endcase
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// File: sv/affine_cipher_character_top.sv
`default_nettype none
// Affine cipher over a 69-symbol alphabet (a-z , . - _ A-Z space 0-9 ( )), one byte per
// beat. Encrypt maps index p to (key_mult*p + key_add) mod 69, decrypt to
// inv(key_mult)*(p - key_add) mod 69; keys above 68 are reduced mod 69 first. Bytes outside
// the alphabet pass through with in_alphabet low. Decrypting with a key_mult that has no
// inverse mod 69 passes every byte through and raises key_error. The block takes one beat
// per cycle unless out_stall holds it; a beat goes from acceptance to the output register
// via lookup, operand select, multiply, reciprocal estimate and remainder/map stages, each
// advancing on its own so bubbles close up under out_stall. Keys are at APB byte addresses
// 0 (key_mult), 4 (key_add) and 8 (decrypt_mode); write them only while idle.
module affine_cipher_character_top (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         in_valid,
  output logic                        in_stall,
  input  wire  aff_pkg::char_t        in_char_in,
  output logic                        out_valid,
  input  wire                         out_stall,
  output aff_pkg::char_t              out_char_out,
  output logic                        out_in_alphabet,
  output logic                        out_key_error,
  input  wire                         psel,
  input  wire                         penable,
  input  wire                         pwrite,
  input  wire  [aff_pkg::PADDR_W-1:0] paddr,
  input  wire  [aff_pkg::PDATA_W-1:0] pwdata,
  output logic [aff_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);
  import aff_pkg::*;

  localparam int unsigned NSTG = 5;

  idx_t  key_mult_r;
  idx_t  key_add_r;
  logic  decrypt_mode_r;

  logic [NSTG:1]   v_r;
  logic [NSTG+1:1] rdy;

  char_t s1_char_r;
  sym_t  s1_sym_r;

  char_t s2_char_r;
  logic  s2_found_r, s2_err_r;
  idx_t  s2_x_r, s2_m_r, s2_add_r;

  char_t              s3_char_r;
  logic               s3_found_r, s3_err_r;
  logic [PROD_W-1:0]  s3_prod_r;
  idx_t               s3_add_r;

  char_t              s4_char_r;
  logic               s4_found_r, s4_err_r;
  logic [PROD_W-1:0]  s4_sum_r;
  idx_t               s4_qe_r;

  idx_t  key_a, key_b, key_inv;
  logic  key_err;
  logic [PROD_W-1:0] sum_nxt;
  logic [PROD_W+RECIP_W-1:0] est;
  logic [PROD_W-1:0] rem;
  idx_t  rem_idx;
  logic  cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_mult_r     <= IDX_W'(1);
      key_add_r      <= '0;
      decrypt_mode_r <= 1'b0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_KEY_MULT:     key_mult_r     <= pwdata[IDX_W-1:0];
        REG_KEY_ADD:      key_add_r      <= pwdata[IDX_W-1:0];
        REG_DECRYPT_MODE: decrypt_mode_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_KEY_MULT:     prdata = PDATA_W'(key_mult_r);
      REG_KEY_ADD:      prdata = PDATA_W'(key_add_r);
      REG_DECRYPT_MODE: prdata = PDATA_W'(decrypt_mode_r);
      default:          prdata = '0;
    endcase
  end

  assign key_a   = aff_reduce(key_mult_r);
  assign key_b   = aff_reduce(key_add_r);
  assign key_inv = aff_inv(key_a);
  assign key_err = decrypt_mode_r && (key_inv == '0);

  always_comb begin
    rdy[NSTG+1] = !out_stall;
    for (int k = NSTG; k >= 1; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
  end
  assign in_stall = !rdy[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (rdy[1]) v_r[1] <= in_valid;
      for (int k = 2; k <= NSTG; k++) begin
        if (rdy[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  assign sum_nxt = s3_prod_r + PROD_W'(s3_add_r);
  assign est     = sum_nxt * RECIP_W'(RECIP);
  assign rem     = s4_sum_r - PROD_W'(s4_qe_r) * PROD_W'(ALPHA_LEN);
  assign rem_idx = (rem >= PROD_W'(ALPHA_LEN)) ? IDX_W'(rem - PROD_W'(ALPHA_LEN))
                                               : IDX_W'(rem);

  always_ff @(posedge clk) begin
    if (rdy[1] && in_valid) begin
      s1_char_r <= in_char_in;
      s1_sym_r  <= aff_lookup(in_char_in);
    end
    if (rdy[2] && v_r[1]) begin
      s2_char_r  <= s1_char_r;
      s2_found_r <= s1_sym_r.found;
      s2_err_r   <= key_err;
      s2_x_r     <= decrypt_mode_r ? aff_sub_mod(s1_sym_r.idx, key_b) : s1_sym_r.idx;
      s2_m_r     <= decrypt_mode_r ? key_inv : key_a;
      s2_add_r   <= decrypt_mode_r ? '0 : key_b;
    end
    if (rdy[3] && v_r[2]) begin
      s3_char_r  <= s2_char_r;
      s3_found_r <= s2_found_r;
      s3_err_r   <= s2_err_r;
      s3_prod_r  <= PROD_W'(s2_x_r) * PROD_W'(s2_m_r);
      s3_add_r   <= s2_add_r;
    end
    if (rdy[4] && v_r[3]) begin
      s4_char_r  <= s3_char_r;
      s4_found_r <= s3_found_r;
      s4_err_r   <= s3_err_r;
      s4_sum_r   <= sum_nxt;
      s4_qe_r    <= est[RECIP_SHIFT +: IDX_W];
    end
    if (rdy[5] && v_r[4]) begin
      out_char_out    <= (s4_found_r && !s4_err_r) ? aff_symbol(rem_idx) : s4_char_r;
      out_in_alphabet <= s4_found_r;
      out_key_error   <= s4_err_r;
    end
  end

  assign out_valid = v_r[NSTG];

endmodule
`default_nettype wire

// File: sv/aff_chk.sv
`default_nettype none
module aff_chk (
  input wire                  clk,
  input wire                  rst_n,
  input wire                  in_stall,
  input wire                  out_valid,
  input wire                  out_stall,
  input wire aff_pkg::char_t  out_char_out,
  input wire                  out_in_alphabet,
  input wire                  out_key_error
);
  import aff_pkg::*;

  sym_t out_sym;

  assign out_sym = aff_lookup(out_char_out);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_char_out)
      && $stable(out_in_alphabet) && $stable(out_key_error))
    else $error("result beat changed while stalled");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while output side can drain");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  a_mapped_in_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_in_alphabet |-> out_sym.found)
    else $error("mapped byte outside the alphabet");

  a_in_quiet_ok: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

endmodule

bind affine_cipher_character_top aff_chk u_aff_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_char_out    (out_char_out),
  .out_in_alphabet (out_in_alphabet),
  .out_key_error   (out_key_error)
);
`default_nettype wire

// File: tb/sv/tb_affine_cipher_character_top.sv
`default_nettype none
module tb_affine_cipher_character_top;
  timeunit 1ns;
  timeprecision 1ps;

  import aff_pkg::*;

  localparam int ALPHABET_SIZE = 69;
  localparam logic [8*ALPHABET_SIZE-1:0] SYMBOLS =
    "abcdefghijklmnopqrstuvwxyz,.-_ABCDEFGHIJKLMNOPQRSTUVWXYZ 0123456789()";
  localparam int RANDOM_ITEMS = 1950;
  localparam int SETTLE_CYCLES = 10;
  localparam int CYCLE_LIMIT = 300000;

  typedef struct {
    char_t ch;
    logic  in_alpha;
    logic  key_err;
  } cipher_beat_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  char_t                in_char_in = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  char_t                out_char_out;
  logic                 out_in_alphabet;
  logic                 out_key_error;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [PADDR_W-1:0]   paddr = '0;
  logic [PDATA_W-1:0]   pwdata = '0;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  logic [6:0]           key_mult_q = 7'd1;
  logic [6:0]           key_add_q = 7'd0;
  logic                 decrypt_q = 1'b0;
  logic                 no_idle = 1'b0;
  int                   stall_left = 0;
  int                   fail_count = 0;
  int                   cycle_count = 0;
  cipher_beat_t         ciphered_q[$];

  affine_cipher_character_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_char_in      (in_char_in),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_char_out    (out_char_out),
    .out_in_alphabet (out_in_alphabet),
    .out_key_error   (out_key_error),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic char_t symbol_at(input int idx);
    return SYMBOLS[8*(ALPHABET_SIZE-1-idx) +: 8];
  endfunction

  function automatic int inverse_mod69(input int a);
    int i;
    for (i = 1; i < ALPHABET_SIZE; i++) begin
      if ((a * i) % ALPHABET_SIZE == 1) begin
        return i;
      end
    end
    return 0;
  endfunction

  function automatic cipher_beat_t affine_map(input char_t c);
    cipher_beat_t r;
    int a;
    int b;
    int p;
    int inv;
    int i;
    a = int'(key_mult_q) % ALPHABET_SIZE;
    b = int'(key_add_q) % ALPHABET_SIZE;
    p = -1;
    inv = 0;
    for (i = 0; i < ALPHABET_SIZE; i++) begin
      if (p < 0 && symbol_at(i) == c) begin
        p = i;
      end
    end
    r.ch = c;
    r.in_alpha = (p >= 0);
    r.key_err = 1'b0;
    if (decrypt_q) begin
      inv = inverse_mod69(a);
      r.key_err = (inv == 0);
    end
    if (p >= 0) begin
      if (!decrypt_q) begin
        r.ch = symbol_at((a * p + b) % ALPHABET_SIZE);
      end else if (!r.key_err) begin
        r.ch = symbol_at(((p + ALPHABET_SIZE - b) % ALPHABET_SIZE) * inv % ALPHABET_SIZE);
      end
    end
    return r;
  endfunction

  // Check each result beat, then draw the stall ahead of the next one.
  always @(posedge clk) begin
    cipher_beat_t exp_beat;
    if (rst_n && out_valid && !out_stall) begin
      if (ciphered_q.size() == 0) begin
        $error("unexpected result: char_out %02h", out_char_out);
        fail_count++;
      end else begin
        exp_beat = ciphered_q.pop_front();
        if (out_char_out !== exp_beat.ch) begin
          $error("char_out: expected %02h, got %02h", exp_beat.ch, out_char_out);
          fail_count++;
        end
        if (out_in_alphabet !== exp_beat.in_alpha) begin
          $error("in_alphabet: expected %0b, got %0b", exp_beat.in_alpha, out_in_alphabet);
          fail_count++;
        end
        if (out_key_error !== exp_beat.key_err) begin
          $error("key_error: expected %0b, got %0b", exp_beat.key_err, out_key_error);
          fail_count++;
        end
      end
      stall_left = no_idle ? 0 : $urandom_range(0, 4);
    end else if (stall_left > 0) begin
      stall_left--;
    end
    out_stall <= (stall_left > 0);
  end

  task automatic send_char(input char_t c);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char_in <= c;
    do @(posedge clk); while (in_stall);
    ciphered_q.push_back(affine_map(c));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (ciphered_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write a register, then read it back.
  task automatic write_reg(input logic [1:0] idx, input logic [PDATA_W-1:0] val);
    logic [PDATA_W-1:0] stored;
    stored = (idx == REG_DECRYPT_MODE) ? (val & 32'h1) : (val & 32'h7f);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_KEY_MULT: key_mult_q = val[6:0];
      REG_KEY_ADD:  key_add_q = val[6:0];
      default:      decrypt_q = val[0];
    endcase
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== stored) begin
      $error("register %0d: expected %08h, got %08h", idx, stored, prdata);
      fail_count++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_keys(input logic [6:0] km, input logic [6:0] ka, input logic mode);
    wait_idle();
    write_reg(REG_KEY_MULT, {25'd0, km});
    write_reg(REG_KEY_ADD, {25'd0, ka});
    write_reg(REG_DECRYPT_MODE, {31'd0, mode});
  endtask

  task automatic test_reset_keys();
    send_char(8'h00);
    send_char(8'hff);
    send_char("a");
    send_char(")");
  endtask

  task automatic test_encrypt_extremes();
    set_keys(7'd68, 7'd68, 1'b0);
    send_char("a");
    send_char(")");
    send_char("Z");
    send_char(" ");
    set_keys(7'd127, 7'd127, 1'b0);
    send_char("b");
    send_char("0");
  endtask

  task automatic test_decrypt_inverse();
    set_keys(7'd5, 7'd12, 1'b1);
    send_char("a");
    send_char("(");
    send_char("_");
    set_keys(7'd68, 7'd127, 1'b1);
    send_char(",");
    send_char("9");
    send_char(8'h7f);
  endtask

  task automatic test_key_without_inverse();
    set_keys(7'd0, 7'd7, 1'b1);
    send_char("a");
    send_char(8'hff);
    set_keys(7'd69, 7'd0, 1'b1);
    send_char("Z");
    set_keys(7'd46, 7'd30, 1'b1);
    send_char("5");
    set_keys(7'd3, 7'd1, 1'b1);
    send_char(" ");
  endtask

  task automatic test_encrypt_without_inverse();
    set_keys(7'd0, 7'd127, 1'b0);
    send_char("q");
    send_char(")");
    set_keys(7'd23, 7'd4, 1'b0);
    send_char("A");
  endtask

  function automatic logic [6:0] pick_key();
    case ($urandom_range(0, 7))
      0:       return 7'd0;
      1:       return 7'd1;
      2:       return 7'd68;
      3:       return 7'd69;
      4:       return 7'd127;
      default: return 7'($urandom_range(0, 127));
    endcase
  endfunction

  task automatic test_random_stream();
    int sent;
    int batch;
    int i;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      batch = $urandom_range(40, 160);
      if (batch > RANDOM_ITEMS - sent) begin
        batch = RANDOM_ITEMS - sent;
      end
      set_keys(pick_key(), pick_key(), 1'($urandom_range(0, 1)));
      no_idle = ($urandom_range(0, 3) == 0);
      for (i = 0; i < batch; i++) begin
        if ($urandom_range(0, 4) != 0) begin
          send_char(symbol_at($urandom_range(0, ALPHABET_SIZE - 1)));
        end else begin
          send_char(8'($urandom_range(0, 255)));
        end
      end
      no_idle = 1'b0;
      sent += batch;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_keys();
    test_encrypt_extremes();
    test_decrypt_inverse();
    test_key_without_inverse();
    test_encrypt_without_inverse();
    test_random_stream();
    wait_idle();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: sim.f
sv/aff_pkg.sv
sv/affine_cipher_character_top.sv
sv/aff_chk.sv
tb/sv/tb_affine_cipher_character_top.sv
